### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types, codes and helpers for the JSON string decoder
// Holds the phase, result kind and error code types, the result bundle and
// the UTF-8 encoder used by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package jsu_pkg;

    localparam int MaxResults = 4;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_STR  = 4'd1,
        PH_ESC  = 4'd2,
        PH_HEX1 = 4'd3,
        PH_BSL  = 4'd4,
        PH_LOWU = 4'd5,
        PH_HEX2 = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_EXPECT_QUOTE  = 4'd0,
        ERR_CONTROL       = 4'd1,
        ERR_TRUNC_ESCAPE  = 4'd2,
        ERR_BAD_ESCAPE    = 4'd3,
        ERR_TRUNC_UNICODE = 4'd4,
        ERR_BAD_HEX       = 4'd5,
        ERR_MISSING_LOW   = 4'd6,
        ERR_BAD_LOW       = 4'd7,
        ERR_LONE_LOW      = 4'd8,
        ERR_UNTERMINATED  = 4'd9
    } t_err;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [15:0] HIGH_FIRST = 16'hd800;
    localparam logic [15:0] HIGH_LAST  = 16'hdbff;
    localparam logic [15:0] LOW_FIRST  = 16'hdc00;
    localparam logic [15:0] LOW_LAST   = 16'hdfff;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        t_err       error_code;
    } t_res;

    typedef struct packed {
        logic [2:0]                 cnt;
        t_res [MaxResults-1:0]      ent;
    } t_bundle;

    // Returns {valid, digit value}.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        return r;
    endfunction

    function automatic t_res byte_res(input logic [7:0] b);
        t_res r;
        r.out_byte   = b;
        r.kind       = KIND_BYTE;
        r.error_code = ERR_EXPECT_QUOTE;
        return r;
    endfunction

    function automatic t_bundle utf8_encode(input logic [20:0] cp);
        t_bundle b;
        b = '0;
        if (cp <= 21'h7f) begin
            b.cnt    = 3'd1;
            b.ent[0] = byte_res({1'b0, cp[6:0]});
        end else if (cp <= 21'h7ff) begin
            b.cnt    = 3'd2;
            b.ent[0] = byte_res({3'b110, cp[10:6]});
            b.ent[1] = byte_res({2'b10, cp[5:0]});
        end else if (cp <= 21'hffff) begin
            b.cnt    = 3'd3;
            b.ent[0] = byte_res({4'b1110, cp[15:12]});
            b.ent[1] = byte_res({2'b10, cp[11:6]});
            b.ent[2] = byte_res({2'b10, cp[5:0]});
        end else begin
            b.cnt    = 3'd4;
            b.ent[0] = byte_res({5'b11110, cp[20:18]});
            b.ent[1] = byte_res({2'b10, cp[17:12]});
            b.ent[2] = byte_res({2'b10, cp[11:6]});
            b.ent[3] = byte_res({2'b10, cp[5:0]});
        end
        return b;
    endfunction

endpackage
`default_nettype wire

### rtl/jsu_dec.sv
// ----------------------------------------------------------------------------
// jsu_dec: input register and decode step
// Registers one input byte, then decodes it against the parser state and
// hands a bundle of up to four results to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module jsu_dec (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_end_of_input,
    input  wire logic            i_free,
    output logic                 o_load,
    output jsu_pkg::t_bundle     o_bundle
);

    logic                   r_in_valid, n_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_eoi;
    jsu_pkg::t_phase        r_phase, n_phase;
    logic [1:0]             r_hex_count, n_hex_count;
    logic [15:0]            r_code_accum, n_code_accum;
    logic [9:0]             r_high_half, n_high_half;

    logic                   step;
    logic                   load_in;
    logic [4:0]             hv;
    logic [15:0]            acc;
    logic [20:0]            supp_cp;
    jsu_pkg::t_bundle       bnd;

    assign step    = r_in_valid && i_free;
    assign o_stall = r_in_valid && !i_free;
    assign load_in = i_valid && !o_stall;

    assign hv      = jsu_pkg::hex_val(r_in_byte);
    assign acc     = {r_code_accum[11:0], hv[3:0]};
    assign supp_cp = jsu_pkg::SUPP_BASE + {1'b0, r_high_half, acc[9:0]};

    always_comb begin
        n_in_valid = r_in_valid;
        if (load_in) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        n_high_half  = r_high_half;
        bnd          = '0;

        // A single error result also clears the whole parser state.
        if (step) begin
            case (r_phase)
                jsu_pkg::PH_STR: begin
                    if (r_in_eoi) begin
                        bnd.cnt                 = 3'd1;
                        bnd.ent[0].kind         = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code   = jsu_pkg::ERR_UNTERMINATED;
                    end else if (r_in_byte == jsu_pkg::CH_QUOTE) begin
                        n_phase         = jsu_pkg::PH_IDLE;
                        bnd.cnt         = 3'd1;
                        bnd.ent[0].kind = jsu_pkg::KIND_FINISH;
                    end else if (r_in_byte < jsu_pkg::CH_SPACE) begin
                        bnd.cnt                 = 3'd1;
                        bnd.ent[0].kind         = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code   = jsu_pkg::ERR_CONTROL;
                    end else if (r_in_byte == jsu_pkg::CH_BSLASH) begin
                        n_phase = jsu_pkg::PH_ESC;
                    end else begin
                        bnd.cnt    = 3'd1;
                        bnd.ent[0] = jsu_pkg::byte_res(r_in_byte);
                    end
                end
                jsu_pkg::PH_ESC: begin
                    n_phase = jsu_pkg::PH_STR;
                    bnd.cnt = 3'd1;
                    if (r_in_eoi) begin
                        bnd.ent[0].kind         = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code   = jsu_pkg::ERR_TRUNC_ESCAPE;
                    end else begin
                        case (r_in_byte)
                            jsu_pkg::CH_QUOTE,
                            jsu_pkg::CH_BSLASH,
                            jsu_pkg::CH_SLASH: bnd.ent[0] = jsu_pkg::byte_res(r_in_byte);
                            jsu_pkg::CH_B: bnd.ent[0] = jsu_pkg::byte_res(8'h08);
                            jsu_pkg::CH_F: bnd.ent[0] = jsu_pkg::byte_res(8'h0c);
                            jsu_pkg::CH_N: bnd.ent[0] = jsu_pkg::byte_res(8'h0a);
                            jsu_pkg::CH_R: bnd.ent[0] = jsu_pkg::byte_res(8'h0d);
                            jsu_pkg::CH_T: bnd.ent[0] = jsu_pkg::byte_res(8'h09);
                            jsu_pkg::CH_U: begin
                                n_phase      = jsu_pkg::PH_HEX1;
                                n_hex_count  = 2'd0;
                                n_code_accum = 16'd0;
                                bnd.cnt      = 3'd0;
                            end
                            default: begin
                                bnd.ent[0].kind       = jsu_pkg::KIND_ERROR;
                                bnd.ent[0].error_code = jsu_pkg::ERR_BAD_ESCAPE;
                            end
                        endcase
                    end
                end
                jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                    if (r_in_eoi) begin
                        bnd.cnt                 = 3'd1;
                        bnd.ent[0].kind         = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code   = jsu_pkg::ERR_TRUNC_UNICODE;
                    end else if (!hv[4]) begin
                        bnd.cnt                 = 3'd1;
                        bnd.ent[0].kind         = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code   = jsu_pkg::ERR_BAD_HEX;
                    end else if (r_hex_count != 2'd3) begin
                        n_code_accum = acc;
                        n_hex_count  = r_hex_count + 2'd1;
                    end else begin
                        n_code_accum = acc;
                        n_hex_count  = 2'd0;
                        if (r_phase == jsu_pkg::PH_HEX1) begin
                            if (acc >= jsu_pkg::HIGH_FIRST && acc <= jsu_pkg::HIGH_LAST) begin
                                n_high_half = acc[9:0];
                                n_phase     = jsu_pkg::PH_BSL;
                            end else if (acc >= jsu_pkg::LOW_FIRST &&
                                         acc <= jsu_pkg::LOW_LAST) begin
                                bnd.cnt               = 3'd1;
                                bnd.ent[0].kind       = jsu_pkg::KIND_ERROR;
                                bnd.ent[0].error_code = jsu_pkg::ERR_LONE_LOW;
                            end else begin
                                n_phase = jsu_pkg::PH_STR;
                                bnd     = jsu_pkg::utf8_encode({5'd0, acc});
                            end
                        end else begin
                            if (acc < jsu_pkg::LOW_FIRST || acc > jsu_pkg::LOW_LAST) begin
                                bnd.cnt               = 3'd1;
                                bnd.ent[0].kind       = jsu_pkg::KIND_ERROR;
                                bnd.ent[0].error_code = jsu_pkg::ERR_BAD_LOW;
                            end else begin
                                n_phase     = jsu_pkg::PH_STR;
                                n_high_half = 10'd0;
                                bnd         = jsu_pkg::utf8_encode(supp_cp);
                            end
                        end
                    end
                end
                jsu_pkg::PH_BSL: begin
                    if (r_in_eoi || r_in_byte != jsu_pkg::CH_BSLASH) begin
                        bnd.cnt               = 3'd1;
                        bnd.ent[0].kind       = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code = jsu_pkg::ERR_MISSING_LOW;
                    end else begin
                        n_phase = jsu_pkg::PH_LOWU;
                    end
                end
                jsu_pkg::PH_LOWU: begin
                    if (r_in_eoi || r_in_byte != jsu_pkg::CH_U) begin
                        bnd.cnt               = 3'd1;
                        bnd.ent[0].kind       = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code = jsu_pkg::ERR_MISSING_LOW;
                    end else begin
                        n_phase      = jsu_pkg::PH_HEX2;
                        n_hex_count  = 2'd0;
                        n_code_accum = 16'd0;
                    end
                end
                default: begin
                    n_phase = jsu_pkg::PH_IDLE;
                    if (!r_in_eoi && r_in_byte == jsu_pkg::CH_QUOTE) begin
                        n_phase = jsu_pkg::PH_STR;
                    end else if (r_in_eoi ||
                                 !(r_in_byte inside {jsu_pkg::CH_SPACE, [8'h09:8'h0d]})) begin
                        bnd.cnt               = 3'd1;
                        bnd.ent[0].kind       = jsu_pkg::KIND_ERROR;
                        bnd.ent[0].error_code = jsu_pkg::ERR_EXPECT_QUOTE;
                    end
                end
            endcase

            if (bnd.cnt != 3'd0 && bnd.ent[0].kind == jsu_pkg::KIND_ERROR) begin
                n_phase      = jsu_pkg::PH_IDLE;
                n_hex_count  = 2'd0;
                n_code_accum = 16'd0;
                n_high_half  = 10'd0;
            end
        end
    end

    assign o_load   = step && (bnd.cnt != 3'd0);
    assign o_bundle = bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_phase      <= jsu_pkg::PH_IDLE;
            r_hex_count  <= 2'd0;
            r_code_accum <= 16'd0;
            r_high_half  <= 10'd0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_phase      <= n_phase;
            r_hex_count  <= n_hex_count;
            r_code_accum <= n_code_accum;
            r_high_half  <= n_high_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    a_stall_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall raised with no item held");

    a_error_is_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && bnd.ent[0].kind != jsu_pkg::KIND_BYTE) |-> bnd.cnt == 3'd1)
        else $error("finish or error result shares its bundle");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && bnd.ent[0].kind == jsu_pkg::KIND_ERROR) |=>
            (r_phase == jsu_pkg::PH_IDLE && r_high_half == 10'd0))
        else $error("parser state not cleared after an error");

endmodule
`default_nettype wire

### rtl/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf: result register
// Holds one bundle of up to four results and presents them one per cycle
// while not stalled, marking the final one of the bundle.
// ----------------------------------------------------------------------------
`default_nettype none
module jsu_outbuf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire jsu_pkg::t_bundle  i_bundle,
    output logic                   o_free,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_out_byte,
    output logic [1:0]             o_kind,
    output logic [3:0]             o_error_code,
    output logic                   o_last
);

    logic                   r_valid, n_valid;
    logic [1:0]             r_idx, n_idx;
    logic [2:0]             r_cnt;
    jsu_pkg::t_res [jsu_pkg::MaxResults-1:0] r_ent;
    jsu_pkg::t_res          sel;
    logic                   last;

    assign sel  = r_ent[r_idx];
    assign last = ({1'b0, r_idx} == r_cnt - 3'd1);

    // The bundle register frees up as its final result is transferred.
    assign o_free = !r_valid || (!i_stall && last);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (r_valid && !i_stall) begin
            if (last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt <= i_bundle.cnt;
            r_ent <= i_bundle.ent;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = sel.out_byte;
    assign o_kind       = sel.kind;
    assign o_error_code = sel.error_code;
    assign o_last       = last;

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("bundle loaded over one still being sent");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != 3'd0 && r_cnt <= 3'd4 && {1'b0, r_idx} < r_cnt))
        else $error("result index outside its bundle");

    a_nonbyte_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && sel.kind != jsu_pkg::KIND_BYTE) |-> (last && sel.out_byte == 8'd0))
        else $error("finish or error result not final or carries a byte");

endmodule
`default_nettype wire

### rtl/json_string_unescape_utf8.sv
// A transferred byte is held in the input register and decoded, and its results are
// loaded into the result register, from which the first one is offered.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// is not stalled; a byte with more results keeps the result register until all are sent.
// The result register sets the rate: it sends one result per cycle while not stalled.
// Reset (synchronous, active low) empties both registers and returns the
// parser to waiting for an opening quote.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal decoder
// Decodes one raw byte per transfer into UTF-8 bytes, a finish marker or an
// error code.
// ----------------------------------------------------------------------------
`default_nettype none
module json_string_unescape_utf8 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_input,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic [3:0]       o_error_code,
    output logic             o_last
);

    logic              free;
    logic              load;
    jsu_pkg::t_bundle  bundle;

    jsu_dec u_dec (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_free         (free),
        .o_load         (load),
        .o_bundle       (bundle)
    );

    jsu_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_bundle     (bundle),
        .o_free       (free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_kind       (o_kind),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the JSON string literal decoder
// Feeds raw bytes through the input channel, predicts the decoded bytes,
// finish markers and error results, and checks every output transfer in
// order. A directed table comes first, then mostly well-formed random strings
// mixed with truncated, corrupted and noise input, under changing idle and
// stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

    localparam int TOTAL_ITEMS  = 330;
    localparam int PHASE_ITEMS  = 70;
    localparam int PAUSE_AT     = 250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 120;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;

    // The error field reads zero whenever the result is not an error.
    localparam jsu_pkg::t_err NO_ERR = jsu_pkg::ERR_EXPECT_QUOTE;

    localparam logic [7:0] ESC_LETTERS [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                               jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                               jsu_pkg::CH_F, jsu_pkg::CH_N,
                                               jsu_pkg::CH_R, jsu_pkg::CH_T};

    typedef struct {
        logic [7:0]     data;
        jsu_pkg::t_kind kind;
        jsu_pkg::t_err  code;
        logic           last;
    } t_dec_res;

    typedef struct {
        logic [7:0]     data;
        logic           eoi;
        logic           typed;
        jsu_pkg::t_kind kind;
        jsu_pkg::t_err  code;
        logic [7:0]     xdata;
    } t_feed_item;

    typedef struct {
        string          txt;
        logic           eoi;
        jsu_pkg::t_kind kind;
        jsu_pkg::t_err  code;
        logic [7:0]     xdata;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_input;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic [1:0] o_kind;
    logic [3:0] o_error_code;
    logic       o_last;

    // Predictor state.
    jsu_pkg::t_phase dec_phase;
    logic [2:0]      hex_n;
    logic [15:0]     hex_acc;
    logic [9:0]      high_bits;

    t_dec_res   step_out[$];
    t_dec_res   pending_results[$];
    t_feed_item byte_feed[$];
    logic [7:0] draft[$];
    t_dir_row   directed_rows [19];

    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   idle_mode    = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    logic hold_busy    = 1'b0;

    json_string_unescape_utf8 dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_kind         (o_kind),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int send_idle_pct();
        return (idle_mode == 1) ? 53 : (idle_mode == 3) ? 33 : 0;
    endfunction

    function automatic int stall_pct();
        return (idle_mode == 2) ? 53 : (idle_mode == 3) ? 33 : 0;
    endfunction

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------
    function automatic void put_res(input logic [7:0] b, input jsu_pkg::t_kind k,
                                    input jsu_pkg::t_err e);
        t_dec_res r;
        r.data = b;
        r.kind = k;
        r.code = e;
        r.last = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        put_res(b, jsu_pkg::KIND_BYTE, NO_ERR);
    endfunction

    function automatic void parse_error(input jsu_pkg::t_err e);
        dec_phase = jsu_pkg::PH_IDLE;
        hex_n     = '0;
        hex_acc   = '0;
        high_bits = '0;
        put_res(8'h00, jsu_pkg::KIND_ERROR, e);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            put_byte({1'b0, cp[6:0]});
        end else if (cp <= 21'h7ff) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hffff) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void decode_step(input logic [7:0] c, input logic eoi);
        int d;
        step_out = {};
        case (dec_phase)
            jsu_pkg::PH_STR: begin
                if (eoi) parse_error(jsu_pkg::ERR_UNTERMINATED);
                else if (c == jsu_pkg::CH_QUOTE) begin
                    dec_phase = jsu_pkg::PH_IDLE;
                    put_res(8'h00, jsu_pkg::KIND_FINISH, NO_ERR);
                end else if (c < jsu_pkg::CH_SPACE) parse_error(jsu_pkg::ERR_CONTROL);
                else if (c == jsu_pkg::CH_BSLASH) dec_phase = jsu_pkg::PH_ESC;
                else put_byte(c);
            end
            jsu_pkg::PH_ESC: begin
                if (eoi) parse_error(jsu_pkg::ERR_TRUNC_ESCAPE);
                else begin
                    dec_phase = jsu_pkg::PH_STR;
                    case (c)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: put_byte(c);
                        jsu_pkg::CH_B: put_byte(8'h08);
                        jsu_pkg::CH_F: put_byte(8'h0c);
                        jsu_pkg::CH_N: put_byte(8'h0a);
                        jsu_pkg::CH_R: put_byte(8'h0d);
                        jsu_pkg::CH_T: put_byte(8'h09);
                        jsu_pkg::CH_U: begin
                            dec_phase = jsu_pkg::PH_HEX1;
                            hex_n     = '0;
                            hex_acc   = '0;
                        end
                        default: parse_error(jsu_pkg::ERR_BAD_ESCAPE);
                    endcase
                end
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                d = hex_digit(c);
                if (eoi) parse_error(jsu_pkg::ERR_TRUNC_UNICODE);
                else if (d < 0) parse_error(jsu_pkg::ERR_BAD_HEX);
                else begin
                    hex_acc = {hex_acc[11:0], 4'(d)};
                    if (hex_n < 3'd3) begin
                        hex_n = hex_n + 3'd1;
                    end else begin
                        hex_n = '0;
                        if (dec_phase == jsu_pkg::PH_HEX1) begin
                            if (hex_acc >= jsu_pkg::HIGH_FIRST &&
                                hex_acc <= jsu_pkg::HIGH_LAST) begin
                                high_bits = 10'(hex_acc - jsu_pkg::HIGH_FIRST);
                                dec_phase = jsu_pkg::PH_BSL;
                            end else if (hex_acc >= jsu_pkg::LOW_FIRST &&
                                         hex_acc <= jsu_pkg::LOW_LAST) begin
                                parse_error(jsu_pkg::ERR_LONE_LOW);
                            end else begin
                                dec_phase = jsu_pkg::PH_STR;
                                emit_utf8({5'd0, hex_acc});
                            end
                        end else if (hex_acc < jsu_pkg::LOW_FIRST ||
                                     hex_acc > jsu_pkg::LOW_LAST) begin
                            parse_error(jsu_pkg::ERR_BAD_LOW);
                        end else begin
                            dec_phase = jsu_pkg::PH_STR;
                            emit_utf8(jsu_pkg::SUPP_BASE +
                                      21'({high_bits, 10'(hex_acc - jsu_pkg::LOW_FIRST)}));
                            high_bits = '0;
                        end
                    end
                end
            end
            jsu_pkg::PH_BSL: begin
                if (eoi || c != jsu_pkg::CH_BSLASH) parse_error(jsu_pkg::ERR_MISSING_LOW);
                else dec_phase = jsu_pkg::PH_LOWU;
            end
            jsu_pkg::PH_LOWU: begin
                if (eoi || c != jsu_pkg::CH_U) parse_error(jsu_pkg::ERR_MISSING_LOW);
                else begin
                    dec_phase = jsu_pkg::PH_HEX2;
                    hex_n     = '0;
                    hex_acc   = '0;
                end
            end
            default: begin
                dec_phase = jsu_pkg::PH_IDLE;
                if (eoi) parse_error(jsu_pkg::ERR_EXPECT_QUOTE);
                else if (c == jsu_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0d)) begin
                end else if (c == jsu_pkg::CH_QUOTE) dec_phase = jsu_pkg::PH_STR;
                else parse_error(jsu_pkg::ERR_EXPECT_QUOTE);
            end
        endcase
        if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    // Called once per accepted input transfer. Table rows with a typed result
    // still run the predictor so that its state follows the block.
    function automatic void accept_item(input t_feed_item it);
        t_dec_res r;
        decode_step(it.data, it.eoi);
        if (it.typed) begin
            r.data = it.xdata;
            r.kind = it.kind;
            r.code = it.code;
            r.last = 1'b1;
            pending_results.insert(pending_results.size(), r);
        end else begin
            foreach (step_out[k]) pending_results.insert(pending_results.size(), step_out[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic void feed(input logic [7:0] b, input logic eoi);
        t_feed_item it;
        it.data  = eoi ? 8'($urandom_range(255)) : b;
        it.eoi   = eoi;
        it.typed = 1'b0;
        it.kind  = jsu_pkg::KIND_BYTE;
        it.code  = NO_ERR;
        it.xdata = 8'h00;
        byte_feed.insert(byte_feed.size(), it);
    endfunction

    function automatic void build_directed();
        int n;
        directed_rows = '{
            '{"A", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_EXPECT_QUOTE, 8'h00},
            '{"", 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_EXPECT_QUOTE, 8'h00},
            '{"\040\011\012\013\014\015\042\377", 1'b0, jsu_pkg::KIND_BYTE, NO_ERR, 8'hff},
            '{"\040\177\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0, jsu_pkg::KIND_FINISH, NO_ERR,
              8'h00},
            '{"\"\037", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CONTROL, 8'h00},
            '{"\"", 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERMINATED, 8'h00},
            '{"\"\\", 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_ESCAPE, 8'h00},
            '{"\"\\x", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESCAPE, 8'h00},
            '{"\"\\u12", 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_UNICODE, 8'h00},
            '{"\"\\u12g", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX, 8'h00},
            '{"\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uD800\\uDC00\\uDBFF\\uDFFF\"",
              1'b0, jsu_pkg::KIND_FINISH, NO_ERR, 8'h00},
            '{"\"\\uD800x", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LOW, 8'h00},
            '{"\"\\uDBFF\\x", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LOW, 8'h00},
            '{"\"\\uD800", 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_MISSING_LOW, 8'h00},
            '{"\"\\uD800\\u0041", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_LOW, 8'h00},
            '{"\"\\uD800\\uE000", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_LOW, 8'h00},
            '{"\"\\uDC00", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_LONE_LOW, 8'h00},
            '{"\"\\uD800\\u00", 1'b1, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_UNICODE,
              8'h00},
            '{"\"\\uD800\\u0z", 1'b0, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX, 8'h00}
        };
        foreach (directed_rows[r]) begin
            n = directed_rows[r].txt.len();
            for (int i = 0; i < n; i++) feed(directed_rows[r].txt[i], 1'b0);
            if (directed_rows[r].eoi) feed(8'h00, 1'b1);
            // Only the final transfer of a row carries the typed result.
            byte_feed[byte_feed.size() - 1].typed = 1'b1;
            byte_feed[byte_feed.size() - 1].kind  = directed_rows[r].kind;
            byte_feed[byte_feed.size() - 1].code  = directed_rows[r].code;
            byte_feed[byte_feed.size() - 1].xdata = directed_rows[r].xdata;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        return (($urandom_range(1) != 0) ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
    endfunction

    function automatic void add_unicode(input logic [15:0] v);
        draft.insert(draft.size(), jsu_pkg::CH_BSLASH);
        draft.insert(draft.size(), jsu_pkg::CH_U);
        for (int k = 3; k >= 0; k--) draft.insert(draft.size(), hex_char(v[k*4 +: 4]));
    endfunction

    function automatic void add_token();
        int t;
        logic [7:0]  b;
        logic [15:0] v;
        t = $urandom_range(99);
        if (t < 40) begin
            do b = 8'($urandom_range(32, 255));
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
            draft.insert(draft.size(), b);
        end else if (t < 60) begin
            draft.insert(draft.size(), jsu_pkg::CH_BSLASH);
            draft.insert(draft.size(), ESC_LETTERS[$urandom_range(7)]);
        end else if (t < 85) begin
            case ($urandom_range(2))
                0:       v = 16'($urandom_range(16'h7f));
                1:       v = 16'($urandom_range(16'h80, 16'h7ff));
                default: v = 16'($urandom_range(16'h800, 16'hffff));
            endcase
            // Keep single escapes clear of the surrogate range.
            if (v >= jsu_pkg::HIGH_FIRST && v <= jsu_pkg::LOW_LAST) v = v ^ 16'h2000;
            add_unicode(v);
        end else begin
            add_unicode(jsu_pkg::HIGH_FIRST + 16'($urandom_range(10'h3ff)));
            add_unicode(jsu_pkg::LOW_FIRST + 16'($urandom_range(10'h3ff)));
        end
    endfunction

    function automatic void add_random_string();
        int r;
        int p;
        int n_tok;
        draft = {};
        if ($urandom_range(99) < 6) begin
            feed(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
        for (int i = $urandom_range(2); i > 0; i--) begin
            feed(($urandom_range(5) == 0) ? jsu_pkg::CH_SPACE : 8'($urandom_range(9, 13)),
                 1'b0);
        end
        draft.insert(draft.size(), jsu_pkg::CH_QUOTE);
        n_tok = $urandom_range(6);
        for (int i = 0; i < n_tok; i++) add_token();
        draft.insert(draft.size(), jsu_pkg::CH_QUOTE);
        r = $urandom_range(99);
        if (r < 75) begin
            foreach (draft[i]) feed(draft[i], 1'b0);
        end else if (r < 82) begin
            for (int i = 0; i < draft.size() - 1; i++) feed(draft[i], 1'b0);
            feed(8'h00, 1'b1);
        end else if (r < 91) begin
            p = $urandom_range(draft.size() - 1);
            for (int i = 0; i < p; i++) feed(draft[i], 1'b0);
            feed(8'h00, 1'b1);
        end else begin
            draft[$urandom_range(draft.size() - 1)] = 8'($urandom_range(255));
            foreach (draft[i]) feed(draft[i], 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_feed_item it;
        int items_sent;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_in_byte      <= 8'h00;
        i_end_of_input <= 1'b0;
        dec_phase  = jsu_pkg::PH_IDLE;
        hex_n      = '0;
        hex_acc    = '0;
        high_bits  = '0;
        items_sent = 0;
        build_directed();
        while (byte_feed.size() < TOTAL_ITEMS) add_random_string();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_feed.size() != 0) begin
            it = byte_feed.pop_front();
            idle_mode = (items_sent / PHASE_ITEMS) % 4;
            if (items_sent == PAUSE_AT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (items_sent == HOLD_AT) hold_req = 1'b1;
            while (!hold_busy && $urandom_range(99) < send_idle_pct()) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid        <= 1'b1;
            i_in_byte      <= it.data;
            i_end_of_input <= it.eoi;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            accept_item(it);
            items_sent++;
        end
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial begin : receiver
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // Long hold-off so the block fills up and stalls its input.
                hold_done = 1'b1;
                hold_busy = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_busy = 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct());
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_dec_res want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0h/%0d/%0d/%0d",
                             $time, o_out_byte, o_kind, o_error_code, o_last);
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_byte", want.data, o_out_byte);
                    check_field("kind", want.kind, o_kind);
                    check_field("error_code", want.code, o_error_code);
                    check_field("last", want.last, o_last);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
